[hdl/fpat_pkg.sv]
// Shared constants, control word types and microcode ROM for the amount-to-text converter.
package fpat_pkg;

    localparam int BCD_DIGITS = 21;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int AMT_W      = 64;
    localparam int CNT_W      = $clog2(AMT_W);
    localparam int CHAR_W     = 6;
    localparam int STEP_W     = 3;

    localparam int FRAC_DIGITS_NORMAL = 8;
    localparam int FRAC_DIGITS_SIX    = 6;

    localparam logic [CNT_W-1:0] CNT_BITS_LAST  = CNT_W'(AMT_W - 1);
    localparam logic [CNT_W-1:0] CNT_INT_NORMAL = CNT_W'(BCD_DIGITS - FRAC_DIGITS_NORMAL - 1);
    localparam logic [CNT_W-1:0] CNT_INT_SIX    = CNT_W'(BCD_DIGITS - FRAC_DIGITS_SIX - 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(8'h30);
    localparam logic [CHAR_W-1:0] CHAR_DOT  = CHAR_W'(8'h2E);

    localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_DABBLE = 3'd1;
    localparam logic [STEP_W-1:0] STEP_INT    = 3'd2;
    localparam logic [STEP_W-1:0] STEP_BRANCH = 3'd3;
    localparam logic [STEP_W-1:0] STEP_DOT    = 3'd4;
    localparam logic [STEP_W-1:0] STEP_FRAC   = 3'd5;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_DABBLE,
        OP_INT,
        OP_NONE,
        OP_DOT,
        OP_FRAC
    } dp_op_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_IN_ACC,
        COND_CNT_ZERO,
        COND_REST_ZERO,
        COND_REST_AFTER_ZERO
    } jmp_cond_t;

    typedef struct packed {
        dp_op_t             op;
        jmp_cond_t          cond;
        logic [STEP_W-1:0]  target_true;
        logic [STEP_W-1:0]  target_false;
    } ctrl_word_t;

    typedef struct packed {
        logic in_acc;
        logic cnt_zero;
        logic rest_zero;
        logic rest_after_zero;
        logic hold;
    } dp_status_t;

    function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
        ctrl_word_t w;
        unique case (step)
            STEP_IDLE:   w = '{OP_LOAD,   COND_IN_ACC,          STEP_DABBLE, STEP_IDLE};
            STEP_DABBLE: w = '{OP_DABBLE, COND_CNT_ZERO,        STEP_INT,    STEP_DABBLE};
            STEP_INT:    w = '{OP_INT,    COND_CNT_ZERO,        STEP_BRANCH, STEP_INT};
            STEP_BRANCH: w = '{OP_NONE,   COND_REST_ZERO,       STEP_IDLE,   STEP_DOT};
            STEP_DOT:    w = '{OP_DOT,    COND_ALWAYS,          STEP_FRAC,   STEP_FRAC};
            STEP_FRAC:   w = '{OP_FRAC,   COND_REST_AFTER_ZERO, STEP_IDLE,   STEP_FRAC};
            default:     w = '{OP_NONE,   COND_ALWAYS,          STEP_IDLE,   STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

[hdl/fpat_seq.sv]
// Microcode sequencer: step counter, ROM fetch and conditional jumps.
module fpat_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fpat_pkg::dp_status_t  status,
    output fpat_pkg::ctrl_word_t  ctrl
);

    logic [fpat_pkg::STEP_W-1:0] step_reg;
    logic [fpat_pkg::STEP_W-1:0] step_next;
    logic                        cond_hit;

    assign ctrl = fpat_pkg::ucode_rom(step_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            fpat_pkg::COND_ALWAYS:          cond_hit = 1'b1;
            fpat_pkg::COND_IN_ACC:          cond_hit = status.in_acc;
            fpat_pkg::COND_CNT_ZERO:        cond_hit = status.cnt_zero;
            fpat_pkg::COND_REST_ZERO:       cond_hit = status.rest_zero;
            fpat_pkg::COND_REST_AFTER_ZERO: cond_hit = status.rest_after_zero;
            default:                        cond_hit = 1'b1;
        endcase
        if (status.hold)
        begin
            step_next = step_reg;
        end
        else
        begin
            step_next = cond_hit ? ctrl.target_true : ctrl.target_false;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= fpat_pkg::STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

[hdl/fpat_dp.sv]
// Datapath: amount shifter, BCD digit register with add-3, digit scan and output register.
module fpat_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fpat_pkg::ctrl_word_t          ctrl,
    output fpat_pkg::dp_status_t          status,
    input  logic                          cfg_write_en,
    input  logic                          cfg_write_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [fpat_pkg::AMT_W-1:0]    amount,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fpat_pkg::CHAR_W-1:0]   text_char,
    output logic                          last_char
);

    logic                          six_decimal_mode_reg;
    logic [fpat_pkg::AMT_W-1:0]    bin_reg;
    logic [fpat_pkg::AMT_W-1:0]    bin_next;
    logic [fpat_pkg::BCD_W-1:0]    bcd_reg;
    logic [fpat_pkg::BCD_W-1:0]    bcd_next;
    logic [fpat_pkg::BCD_W-1:0]    bcd_add3;
    logic [fpat_pkg::CNT_W-1:0]    cnt_reg;
    logic [fpat_pkg::CNT_W-1:0]    cnt_next;
    logic [fpat_pkg::CNT_W-1:0]    int_last;
    logic                          seen_reg;
    logic                          seen_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [fpat_pkg::CHAR_W-1:0]   text_char_reg;
    logic [fpat_pkg::CHAR_W-1:0]   text_char_next;
    logic                          last_char_reg;
    logic                          last_char_next;
    logic [3:0]                    top_digit;
    logic [fpat_pkg::CHAR_W-1:0]   digit_char;
    logic                          emit_step;
    logic                          hold;
    logic                          in_acc;
    logic                          out_load;
    logic                          rest_zero;
    logic                          rest_after_zero;
    logic                          cnt_zero;

    assign int_last        = six_decimal_mode_reg ? fpat_pkg::CNT_INT_SIX
                                                  : fpat_pkg::CNT_INT_NORMAL;
    assign top_digit       = bcd_reg[fpat_pkg::BCD_W-1 -: 4];
    assign digit_char      = fpat_pkg::CHAR_ZERO + fpat_pkg::CHAR_W'(top_digit);
    assign rest_zero       = (bcd_reg == '0);
    assign rest_after_zero = (bcd_reg[fpat_pkg::BCD_W-5:0] == '0);
    assign cnt_zero        = (cnt_reg == '0);

    assign emit_step = (ctrl.op == fpat_pkg::OP_INT) || (ctrl.op == fpat_pkg::OP_DOT)
                    || (ctrl.op == fpat_pkg::OP_FRAC);
    assign hold      = emit_step && out_valid_reg && out_stall;
    assign in_stall  = (ctrl.op != fpat_pkg::OP_LOAD);
    assign in_acc    = in_valid && !in_stall;

    assign status = '{in_acc:          in_acc,
                      cnt_zero:        cnt_zero,
                      rest_zero:       rest_zero,
                      rest_after_zero: rest_after_zero,
                      hold:            hold};

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < fpat_pkg::BCD_DIGITS; i++)
        begin
            bcd_add3[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                            : bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        seen_next      = seen_reg;
        out_load       = 1'b0;
        text_char_next = text_char_reg;
        last_char_next = last_char_reg;

        if (!hold)
        begin
            unique case (ctrl.op)
                fpat_pkg::OP_LOAD:
                begin
                    if (in_acc)
                    begin
                        bin_next  = amount;
                        bcd_next  = '0;
                        cnt_next  = fpat_pkg::CNT_BITS_LAST;
                        seen_next = 1'b0;
                    end
                end
                fpat_pkg::OP_DABBLE:
                begin
                    bcd_next = {bcd_add3[fpat_pkg::BCD_W-2:0], bin_reg[fpat_pkg::AMT_W-1]};
                    bin_next = {bin_reg[fpat_pkg::AMT_W-2:0], 1'b0};
                    cnt_next = cnt_zero ? int_last : cnt_reg - 1'b1;
                end
                fpat_pkg::OP_INT:
                begin
                    // leading zeros dropped; the units digit always goes out
                    if (seen_reg || (top_digit != 4'd0) || cnt_zero)
                    begin
                        out_load       = 1'b1;
                        text_char_next = digit_char;
                        last_char_next = cnt_zero && rest_after_zero;
                    end
                    seen_next = seen_reg || (top_digit != 4'd0);
                    bcd_next  = {bcd_reg[fpat_pkg::BCD_W-5:0], 4'd0};
                    if (!cnt_zero)
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
                fpat_pkg::OP_DOT:
                begin
                    out_load       = 1'b1;
                    text_char_next = fpat_pkg::CHAR_DOT;
                    last_char_next = 1'b0;
                end
                fpat_pkg::OP_FRAC:
                begin
                    // zeros shift in from below, so an empty tail means trailing zeros
                    out_load       = 1'b1;
                    text_char_next = digit_char;
                    last_char_next = rest_after_zero;
                    bcd_next       = {bcd_reg[fpat_pkg::BCD_W-5:0], 4'd0};
                end
                fpat_pkg::OP_NONE:
                begin
                end
                default:
                begin
                end
            endcase
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            six_decimal_mode_reg <= 1'b0;
            out_valid_reg        <= 1'b0;
            seen_reg             <= 1'b0;
            cnt_reg              <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                six_decimal_mode_reg <= cfg_write_data;
            end
            out_valid_reg <= out_valid_next;
            seen_reg      <= seen_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg       <= bin_next;
        bcd_reg       <= bcd_next;
        text_char_reg <= text_char_next;
        last_char_reg <= last_char_next;
    end

    assign out_valid = out_valid_reg;
    assign text_char = text_char_reg;
    assign last_char = last_char_reg;

    a_hold_freezes_digits: assert property (@(posedge clk) disable iff (!rst_n)
        hold |=> $stable(bcd_reg) && $stable(cnt_reg))
        else $error("digit register moved while output was blocked");

    a_int_count_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == fpat_pkg::OP_DABBLE) && cnt_zero |=> cnt_reg == $past(int_last))
        else $error("integer digit count not loaded after conversion");

    a_units_digit_sent: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == fpat_pkg::OP_INT) && !hold && cnt_zero
        |=> out_valid_reg && (text_char_reg != fpat_pkg::CHAR_DOT))
        else $error("units digit not sent");

    a_dot_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (text_char_reg == fpat_pkg::CHAR_DOT) |-> !last_char_reg)
        else $error("decimal point flagged as last character");

endmodule

[hdl/fixed_point_amount_to_decimal_text.sv]
// Steps: load, shift-add-3 conversion of all 64 amount bits at one bit per cycle, then the scan
// of the integer digit positions (13 or 15), a branch step, and the '.' and fractional digits sent.
// The scan takes one digit position per cycle unless an output stall holds it; the next amount
// is taken only once the sequencer is back in idle after the last character of the previous one.
// Output stalls hold the sequencer only on character steps.
// Reset (rst_n low, asynchronous): sequencer idle, no result pending, eight fractional digits.
module fixed_point_amount_to_decimal_text (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic                          cfg_write_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [fpat_pkg::AMT_W-1:0]    amount,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fpat_pkg::CHAR_W-1:0]   text_char,
    output logic                          last_char
);

    fpat_pkg::ctrl_word_t ctrl;
    fpat_pkg::dp_status_t status;

    fpat_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    fpat_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .status         (status),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .amount         (amount),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .text_char      (text_char),
        .last_char      (last_char)
    );

endmodule

[test/fpat_text_checker.sv]
// Checker for the amount-to-text converter: predicts each amount's characters and compares.
module fpat_text_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic                          cfg_write_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [fpat_pkg::AMT_W-1:0]    amount,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [fpat_pkg::CHAR_W-1:0]   text_char,
    input  logic                          last_char,
    output int                            mismatches,
    output int                            pending
);

    typedef struct packed {
        logic [fpat_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } text_item_t;

    text_item_t expected_text[$];
    logic       six_digit_frac;

    task automatic predict_text(input logic [fpat_pkg::AMT_W-1:0] value);
        logic [3:0]  digits [fpat_pkg::BCD_DIGITS];
        logic [fpat_pkg::AMT_W-1:0] rest;
        text_item_t  chars [fpat_pkg::BCD_DIGITS + 1];
        int          n;
        int          int_len;
        int          frac_len;
        int          last_nz;
        bit          leading;
        rest = value;
        // 2^64 fits in 20 decimal digits, so plain division gives the BCD string
        for (int k = fpat_pkg::BCD_DIGITS - 1; k >= 0; k--)
        begin
            digits[k] = 4'(rest % 64'd10);
            rest      = rest / 64'd10;
        end
        frac_len = six_digit_frac ? fpat_pkg::FRAC_DIGITS_SIX : fpat_pkg::FRAC_DIGITS_NORMAL;
        int_len  = fpat_pkg::BCD_DIGITS - frac_len;
        n        = 0;
        leading  = 1'b1;
        for (int k = 0; k < int_len; k++)
        begin
            if (!leading || digits[k] != 4'd0)
            begin
                leading  = 1'b0;
                chars[n] = '{fpat_pkg::CHAR_ZERO + fpat_pkg::CHAR_W'(digits[k]), 1'b0};
                n        = n + 1;
            end
        end
        if (leading)
        begin
            chars[n] = '{fpat_pkg::CHAR_ZERO, 1'b0};
            n        = n + 1;
        end
        last_nz = -1;
        for (int k = 0; k < frac_len; k++)
            if (digits[int_len + k] != 4'd0)
                last_nz = k;
        if (last_nz >= 0)
        begin
            chars[n] = '{fpat_pkg::CHAR_DOT, 1'b0};
            n        = n + 1;
            for (int k = 0; k <= last_nz; k++)
            begin
                chars[n] = '{fpat_pkg::CHAR_ZERO + fpat_pkg::CHAR_W'(digits[int_len + k]),
                             1'b0};
                n        = n + 1;
            end
        end
        chars[n - 1].last = 1'b1;
        for (int k = 0; k < n; k++)
            expected_text.push_back(chars[k]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        text_item_t want;
        if (!rst_n)
        begin
            six_digit_frac <= 1'b0;
            mismatches     = 0;
            pending        <= 0;
        end
        else
        begin
            // mode change takes effect after this edge, as in the block
            if (cfg_write_en)
                six_digit_frac <= cfg_write_data;
            if (in_valid && !in_stall)
                predict_text(amount);
            if (out_valid && !out_stall)
            begin
                if (expected_text.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected char: expected none, actual char %0d last %0b",
                             $time, text_char, last_char);
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (want.ch !== text_char)
                    begin
                        mismatches++;
                        $display("%0t: text_char mismatch: expected %0d, actual %0d",
                                 $time, want.ch, text_char);
                    end
                    if (want.last !== last_char)
                    begin
                        mismatches++;
                        $display("%0t: last_char mismatch: expected %0b, actual %0b",
                                 $time, want.last, last_char);
                    end
                end
            end
            pending <= expected_text.size();
        end
    end

endmodule

[test/tb_fixed_point_amount_to_decimal_text.sv]
// Testbench top for the amount-to-text converter: stimulus, idling and verdict.
module tb_fixed_point_amount_to_decimal_text;

    logic                          clk            = 1'b0;
    logic                          rst_n          = 1'b0;
    logic                          cfg_write_en   = 1'b0;
    logic                          cfg_write_data = 1'b0;
    logic                          in_valid       = 1'b0;
    logic                          in_stall;
    logic [fpat_pkg::AMT_W-1:0]    amount         = '0;
    logic                          out_valid;
    logic                          out_stall      = 1'b0;
    logic [fpat_pkg::CHAR_W-1:0]   text_char;
    logic                          last_char;

    int mismatches;
    int pending;

    bit calm_stretch = 1'b0;
    bit hold_armed   = 1'b0;
    bit hold_done    = 1'b0;

    logic [fpat_pkg::AMT_W-1:0] corner_amounts [12] = '{
        64'd0,
        64'd1,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'd100000000,
        64'd1000000,
        64'd12345678,
        64'd100000005,
        64'd10,
        64'd99999999,
        64'd10000000000000000000,
        64'h8000_0000_0000_0000,
        64'd123456789012345678
    };

    always #5 clk = ~clk;

    fixed_point_amount_to_decimal_text dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .amount         (amount),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .text_char      (text_char),
        .last_char      (last_char)
    );

    fpat_text_checker text_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .amount         (amount),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .text_char      (text_char),
        .last_char      (last_char),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    function automatic logic [fpat_pkg::AMT_W-1:0] pick_amount();
        logic [fpat_pkg::AMT_W-1:0] raw;
        logic [fpat_pkg::AMT_W-1:0] scale;
        int                         p;
        raw   = {$urandom, $urandom};
        scale = 64'd1;
        case ($urandom_range(5))
            0: return raw;
            1: return raw % 64'd1000000000;
            2: return raw >> $urandom_range(63);
            3:
            begin
                // trailing zeros land anywhere in the fraction or integer part
                p = $urandom_range(14);
                repeat (p) scale = scale * 64'd10;
                return (raw % 64'd100000000) * scale;
            end
            4: return (raw % 64'd10000000) * 64'd100000000;
            default:
            begin
                p = $urandom_range(19);
                repeat (p) scale = scale * 64'd10;
                return scale - 64'($urandom_range(1));
            end
        endcase
    endfunction

    task automatic send_amount(input logic [fpat_pkg::AMT_W-1:0] value);
        while (!calm_stretch && $urandom_range(99) < 30)
        begin
            in_valid <= 1'b0;
            amount   <= {$urandom, $urandom};
            @(posedge clk);
        end
        in_valid <= 1'b1;
        amount   <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic set_frac_mode(input logic six_digits);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // let the sequencer settle back to idle after the final character
        repeat (8) @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= six_digits;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        cfg_write_data <= 1'($urandom_range(1));
    endtask

    // receiver: random stalls, one long hold-off once armed
    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (hold_armed && !hold_done)
            begin
                hold_done = 1'b1;
                repeat (400)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= !calm_stretch && ($urandom_range(99) < 30);
        end
    end

    initial
    begin : stimulus
        logic start_mode;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_frac_mode(1'b0);
        foreach (corner_amounts[i])
            send_amount(corner_amounts[i]);
        set_frac_mode(1'b1);
        foreach (corner_amounts[i])
            send_amount(corner_amounts[i]);

        start_mode = 1'($urandom_range(1));
        for (int phase = 0; phase < 4; phase++)
        begin
            set_frac_mode(start_mode ^ phase[0]);
            hold_armed   = (phase == 1);
            calm_stretch = (phase == 2);
            for (int i = 0; i < 26; i++)
                send_amount(pick_amount());
            calm_stretch = 1'b0;
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin : watchdog
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule
